@@ hw/rtl/mctw_pkg.sv @@
package mctw_pkg;

   // Table geometry
   localparam int SLOTS       = 8;
   localparam int ID_BITS     = 8;
   localparam int MAX_RESULTS = 8;
   localparam int SLOT_BITS   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_BITS    = $clog2(MAX_RESULTS + 1);

   typedef logic [ID_BITS-1:0]   id_type;
   typedef logic [SLOT_BITS-1:0] slot_type;
   typedef logic [CNT_BITS-1:0]  cnt_type;
   typedef logic [31:0]          tick_type;

   // One slot entry as held in the slot RAM
   typedef struct packed {
      id_type   owner;
      tick_type limit;
      tick_type last_kick;
   } entry_type;

   localparam int ENTRY_BITS = $bits(entry_type);

   typedef enum logic [2:0] {
      CMD_REGISTER   = 3'd0,
      CMD_KICK       = 3'd1,
      CMD_UNREGISTER = 3'd2,
      CMD_QUERY      = 3'd3,
      CMD_CHECK      = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      STS_OK       = 3'd0,
      STS_FULL     = 3'd1,
      STS_NOREG    = 3'd2,
      STS_TIMEOUT  = 3'd3,
      STS_NONE     = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_REG,
      FSM_SCAN,
      FSM_FLUSH
   } fsm_type;

   // One result word
   typedef struct packed {
      status_type   status;
      logic [2:0]   slot_index;
      logic [7:0]   owner_id;
      tick_type     kick_age;
      logic         last;
   } rsp_word_type;

   // Controller to output stage
   typedef struct packed {
      logic         valid;
      rsp_word_type word;
   } rsp_push_type;

endpackage

@@ hw/rtl/mctw_req_if.sv @@
interface mctw_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  cmd;
   logic [7:0]  client_id;
   logic [31:0] timeout_ticks;
   logic [31:0] now_ticks;

   modport source (output valid, cmd, client_id, timeout_ticks, now_ticks, input ready);
   modport sink   (input valid, cmd, client_id, timeout_ticks, now_ticks, output ready);
endinterface

@@ hw/rtl/mctw_rsp_if.sv @@
interface mctw_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [2:0]  slot_index;
   logic [7:0]  owner_id;
   logic [31:0] kick_age;
   logic        last;

   modport source (output valid, status, slot_index, owner_id, kick_age, last,
                   input ready);
   modport sink   (input valid, status, slot_index, owner_id, kick_age, last,
                   output ready);
endinterface

@@ hw/rtl/mctw_ram.sv @@
module mctw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 we,
   input  logic [ADDR_BITS-1:0] waddr,
   input  logic [WIDTH-1:0]     wdata,
   input  logic [ADDR_BITS-1:0] raddr,
   output logic [WIDTH-1:0]     rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ hw/rtl/mctw_rsp_stage.sv @@
module mctw_rsp_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  mctw_pkg::rsp_push_type push,
   output logic                  out_free,
   mctw_rsp_if.source            rsp_chan
);
   import mctw_pkg::*;

   logic         valid_ff, valid_in;
   rsp_word_type word_ff;

   // Slot is free when empty or being drained this cycle
   assign out_free = !valid_ff || rsp_chan.ready;
   assign valid_in = push.valid || (valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         word_ff <= push.word;
      end
   end

   assign rsp_chan.valid      = valid_ff;
   assign rsp_chan.status     = word_ff.status;
   assign rsp_chan.slot_index = word_ff.slot_index;
   assign rsp_chan.owner_id   = word_ff.owner_id;
   assign rsp_chan.kick_age   = word_ff.kick_age;
   assign rsp_chan.last       = word_ff.last;

endmodule

@@ hw/rtl/mctw_ctrl.sv @@
module mctw_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   mctw_req_if.sink               req_chan,
   input  logic                   out_free,
   output mctw_pkg::rsp_push_type push,
   output logic                   ram_we,
   output mctw_pkg::slot_type     ram_waddr,
   output mctw_pkg::entry_type    ram_wdata,
   output mctw_pkg::slot_type     ram_raddr,
   input  mctw_pkg::entry_type    ram_rdata
);
   import mctw_pkg::*;

   fsm_type          state_ff, state_in;
   slot_type         idx_ff, idx_in;
   cnt_type          cnt_ff, cnt_in;
   logic [SLOTS-1:0] valid_ff, valid_in;
   logic             pend_valid_ff, pend_valid_in;
   rsp_word_type     pend_ff, pend_in;

   // Latched request word
   logic [2:0]       cmd_ff;
   id_type           id_ff;
   tick_type         tmo_ff;
   tick_type         now_ff;

   tick_type         elapsed;
   logic             cur_valid;
   logic             hit;
   logic             expired;
   logic             at_end;
   logic             free_found;
   slot_type         free_idx;

   assign req_chan.ready = (state_ff == FSM_IDLE);

   // Evaluation of the entry read last cycle
   assign elapsed   = now_ff - ram_rdata.last_kick;
   assign cur_valid = valid_ff[idx_ff];
   assign hit       = cur_valid && (ram_rdata.owner == id_ff);
   assign expired   = cur_valid && (elapsed > ram_rdata.limit);
   assign at_end    = (idx_ff == slot_type'(SLOTS - 1));

   // First free slot from the valid flops
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = slot_type'(i);
         end
      end
   end

   // Next state and outputs
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      valid_in      = valid_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      push          = '0;
      ram_we        = 1'b0;
      ram_waddr     = idx_ff;
      ram_wdata     = ram_rdata;
      ram_raddr     = idx_ff;

      case (state_ff)
         FSM_IDLE: begin
            ram_raddr = '0;
            if (req_chan.valid) begin
               idx_in        = '0;
               cnt_in        = '0;
               pend_valid_in = 1'b0;
               case (req_chan.cmd)
                  CMD_REGISTER:   state_in = FSM_REG;
                  CMD_KICK:       state_in = FSM_SCAN;
                  CMD_UNREGISTER: state_in = FSM_SCAN;
                  CMD_QUERY:      state_in = FSM_SCAN;
                  CMD_CHECK:      state_in = FSM_SCAN;
                  default:        state_in = FSM_IDLE;
               endcase
            end
         end

         FSM_REG: begin
            if (out_free) begin
               push.valid         = 1'b1;
               push.word.owner_id = 8'(id_ff);
               push.word.last     = 1'b1;
               if (free_found) begin
                  push.word.status     = STS_OK;
                  push.word.slot_index = 3'(free_idx);
                  ram_we               = 1'b1;
                  ram_waddr            = free_idx;
                  ram_wdata            = '{owner: id_ff, limit: tmo_ff, last_kick: now_ff};
                  valid_in[free_idx]   = 1'b1;
               end else begin
                  push.word.status     = STS_FULL;
               end
               state_in = FSM_IDLE;
            end
         end

         FSM_SCAN: begin
            if (cmd_ff == CMD_CHECK) begin
               // Hold on this slot while the previous timeout cannot leave
               if (!(expired && pend_valid_ff && !out_free)) begin
                  if (expired) begin
                     if (pend_valid_ff) begin
                        push.valid = 1'b1;
                        push.word  = pend_ff;
                     end
                     pend_in       = '{status: STS_TIMEOUT, slot_index: 3'(idx_ff),
                                       owner_id: 8'(ram_rdata.owner),
                                       kick_age: elapsed, last: 1'b0};
                     pend_valid_in    = 1'b1;
                     valid_in[idx_ff] = 1'b0;
                     cnt_in           = cnt_ff + cnt_type'(1);
                  end
                  if (at_end || (expired && cnt_ff == cnt_type'(MAX_RESULTS - 1))) begin
                     state_in = FSM_FLUSH;
                  end else begin
                     idx_in    = idx_ff + slot_type'(1);
                     ram_raddr = idx_ff + slot_type'(1);
                  end
               end
            end else if (hit) begin
               if (out_free) begin
                  push.valid           = 1'b1;
                  push.word.status     = STS_OK;
                  push.word.slot_index = 3'(idx_ff);
                  push.word.owner_id   = 8'(ram_rdata.owner);
                  push.word.kick_age   = elapsed;
                  push.word.last       = 1'b1;
                  if (cmd_ff == CMD_KICK) begin
                     ram_we              = 1'b1;
                     ram_wdata.last_kick = now_ff;
                  end
                  if (cmd_ff == CMD_UNREGISTER) begin
                     valid_in[idx_ff] = 1'b0;
                  end
                  state_in = FSM_IDLE;
               end
            end else if (at_end) begin
               if (out_free) begin
                  push.valid         = 1'b1;
                  push.word.status   = STS_NOREG;
                  push.word.owner_id = 8'(id_ff);
                  push.word.last     = 1'b1;
                  state_in           = FSM_IDLE;
               end
            end else begin
               idx_in    = idx_ff + slot_type'(1);
               ram_raddr = idx_ff + slot_type'(1);
            end
         end

         FSM_FLUSH: begin
            if (out_free) begin
               push.valid = 1'b1;
               if (pend_valid_ff) begin
                  push.word      = pend_ff;
                  push.word.last = 1'b1;
               end else begin
                  push.word.status = STS_NONE;
                  push.word.last   = 1'b1;
               end
               pend_valid_in = 1'b0;
               state_in      = FSM_IDLE;
            end
         end

         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= FSM_IDLE;
         idx_ff        <= '0;
         cnt_ff        <= '0;
         valid_ff      <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         cnt_ff        <= cnt_in;
         valid_ff      <= valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      if (req_chan.valid && req_chan.ready) begin
         cmd_ff <= req_chan.cmd;
         id_ff  <= ID_BITS'(req_chan.client_id);
         tmo_ff <= req_chan.timeout_ticks;
         now_ff <= req_chan.now_ticks;
      end
   end

   // A result is only pushed into a free output stage
   a_push_free: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> out_free)
      else $error("result pushed into a full output stage");

   // The slot RAM is written only in the register and scan states (by register and kick)
   a_write_state: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == FSM_REG) || (state_ff == FSM_SCAN))
      else $error("slot RAM written outside register or scan");

   // An unused command produces nothing
   a_unused_silent: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && (req_chan.cmd > CMD_CHECK)) |=> !push.valid)
      else $error("unused command produced a result");

   // A held timeout exists only during a check
   a_pend_scope: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> (state_ff == FSM_SCAN) || (state_ff == FSM_FLUSH))
      else $error("pending timeout outside a check");

endmodule

@@ hw/rtl/multi_channel_task_watchdog.sv @@
// Watchdog table of SLOTS client slots. Owner, timeout and last-kick time sit in one
// slot RAM with a registered read; the valid bits are flip-flops cleared by reset.
// One command word is taken at a time. Kick, unregister and query walk the RAM one
// slot per cycle from slot 0 and finish at the first matching slot. Check walks every
// slot, one per cycle unless a found timeout must wait for the result side, and holds
// the last timeout back until the walk ends so that its last flag is known.
// Results leave through a one-word output register.
module multi_channel_task_watchdog (
   input logic        clock,
   input logic        reset,
   mctw_req_if.sink   req_chan,
   mctw_rsp_if.source rsp_chan
);
   import mctw_pkg::*;

   rsp_push_type push;
   logic         out_free;
   logic         ram_we;
   slot_type     ram_waddr;
   slot_type     ram_raddr;
   entry_type    ram_wdata;
   entry_type    ram_rdata;

   mctw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .out_free  (out_free),
      .push      (push),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata)
   );

   mctw_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   mctw_rsp_stage u_rsp_stage (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .out_free (out_free),
      .rsp_chan (rsp_chan)
   );

endmodule
